// File: rtl/csa_prg_pkg.sv
// Package for the charge-sensitive amplifier pulse-response generator.
// Holds field widths, command and register codes, caps and reset values.
// No dependencies; every other file of the block imports it.
package csa_prg_pkg;

    localparam int unsigned MAX_POINTS  = 65535;
    localparam int unsigned MAX_SAMPLES = 65535;

    localparam int ACTION_W    = 2;
    localparam int SAMPLE_W    = 32;
    localparam int CHARGE_W    = 24;
    localparam int VALUE_W     = 32;
    localparam int POINT_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Command codes carried in the action field.
    localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STEP  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN          = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_RATIO   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FALL_PER_STEP = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_POINTS = 2'd3;

    // Caps on the point count and the number of accepted loads.
    localparam logic [POINT_W-1:0] POINT_CAP =
        (MAX_POINTS < 65535) ? POINT_W'(MAX_POINTS) : {POINT_W{1'b1}};
    localparam logic [POINT_W-1:0] SAMPLE_CAP =
        (MAX_SAMPLES < 65535) ? POINT_W'(MAX_SAMPLES) : {POINT_W{1'b1}};

    // Register reset values.
    localparam logic [31:0] GAIN_RESET          = 32'h0001_0000;
    localparam logic [31:0] DECAY_RATIO_RESET   = 32'hF000_0000;
    localparam logic [31:0] FALL_PER_STEP_RESET = 32'h0000_0000;
    localparam logic [15:0] OUTPUT_POINTS_RESET = 16'd1024;

    // One in Q0.32, saturated, and the most negative sample.
    localparam logic [31:0]        ONE_Q32       = 32'hFFFF_FFFF;
    localparam logic signed [31:0] PEAK_RESET    = 32'sh8000_0000;

endpackage

// File: rtl/csa_prg_cmd_if.sv
// Command channel of the pulse-response generator: valid, ready and one item.
// Depends on csa_prg_pkg for the field widths.
interface csa_prg_cmd_if;
    import csa_prg_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [CHARGE_W-1:0] charge;

    modport source (output valid, action, sample, charge, input ready);
    modport sink   (input valid, action, sample, charge, output ready);
endinterface

// File: rtl/csa_prg_resp_if.sv
// Result channel of the pulse-response generator: valid, ready and one item.
// Depends on csa_prg_pkg for the field widths.
interface csa_prg_resp_if;
    import csa_prg_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [POINT_W-1:0] point_index;
    logic               last;
    logic               beyond_end;

    modport source (output valid, value, point_index, last, beyond_end, input ready);
    modport sink   (input valid, value, point_index, last, beyond_end, output ready);
endinterface

// File: rtl/csa_prg_cfg_if.sv
// Configuration write channel of the pulse-response generator.
// Depends on csa_prg_pkg for the index and data widths.
interface csa_prg_cfg_if;
    import csa_prg_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/csa_pulse_response_generator.sv
// A load is handled in IDLE; a start scales the charge in CHG_LO and CHG_HI; neither gives a
// result. A step before the peak or past the end goes to EMIT; one on the response passes
// RISE_LO, RISE_HI, DEC_LO and DEC_HI before it. EMIT waits for a free output register.
// One item at a time. The shared 40x16 multiplier takes two passes for the rise product
// and two for the decay power. The output register frees the result from the next item.
// Reset (rst_n, asynchronous) restores the register defaults and clears the pulse state.
module csa_pulse_response_generator (
    input  logic           clk,
    input  logic           rst_n,
    csa_prg_cmd_if.sink    cmd,
    csa_prg_resp_if.source resp,
    csa_prg_cfg_if.sink    cfg
);
    import csa_prg_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        CHG_LO,
        CHG_HI,
        RISE_LO,
        RISE_HI,
        DEC_LO,
        DEC_HI,
        EMIT
    } state_t;

    // Configuration registers.
    logic [31:0]        gain_reg;
    logic [31:0]        decay_ratio_reg;
    logic [31:0]        fall_per_step_reg;
    logic [POINT_W-1:0] output_points_reg;

    // Pulse state.
    logic [39:0]        scaled_charge_reg;
    logic signed [31:0] peak_value_reg;
    logic [POINT_W-1:0] peak_index_reg;
    logic [POINT_W-1:0] samples_loaded_reg;
    logic [POINT_W-1:0] step_index_reg;
    logic [31:0]        decay_power_reg;
    logic [47:0]        fall_total_reg;

    // Sequencer and shared multiplier datapath.
    state_t             state_reg;
    logic [39:0]        mul_a_reg;
    logic [39:0]        acc_reg;
    logic [40:0]        amp_reg;
    logic [15:0]        mul_b;
    logic [55:0]        mul_p;
    logic [56:0]        mul_sum;
    logic [31:0]        rise;

    // Pending result and output register.
    logic [VALUE_W-1:0] res_value_reg;
    logic [POINT_W-1:0] res_index_reg;
    logic               res_last_reg;
    logic               res_beyond_reg;
    logic               resp_valid_reg;
    logic [VALUE_W-1:0] resp_value_reg;
    logic [POINT_W-1:0] resp_index_reg;
    logic               resp_last_reg;
    logic               resp_beyond_reg;

    // Helpers.
    logic [POINT_W-1:0] point_count;
    logic               step_past_end;
    logic               step_is_last;
    logic [47:0]        amp_ext;
    logic [47:0]        fall_diff;
    logic [VALUE_W-1:0] value_clamped;
    logic [48:0]        fall_sum;
    logic [47:0]        fall_sat;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg          <= GAIN_RESET;
            decay_ratio_reg   <= DECAY_RATIO_RESET;
            fall_per_step_reg <= FALL_PER_STEP_RESET;
            output_points_reg <= OUTPUT_POINTS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_GAIN:          gain_reg          <= cfg.data;
                REG_DECAY_RATIO:   decay_ratio_reg   <= cfg.data;
                REG_FALL_PER_STEP: fall_per_step_reg <= cfg.data;
                REG_OUTPUT_POINTS: output_points_reg <= cfg.data[POINT_W-1:0];
                default: ;
            endcase
        end
    end

    assign rise = ONE_Q32 - decay_power_reg;

    // Every product is built from two 16-bit halves of the second operand:
    // the low pass keeps floor(a*lo/2^16), the high pass adds a*hi.
    always_comb
    begin
        unique case (state_reg)
            CHG_LO:  mul_b = gain_reg[15:0];
            CHG_HI:  mul_b = gain_reg[31:16];
            RISE_LO: mul_b = rise[15:0];
            RISE_HI: mul_b = rise[31:16];
            DEC_LO:  mul_b = decay_ratio_reg[15:0];
            DEC_HI:  mul_b = decay_ratio_reg[31:16];
            default: mul_b = 16'd0;
        endcase
    end

    assign mul_p   = mul_a_reg * mul_b;
    assign mul_sum = {1'b0, mul_p} + {17'd0, acc_reg};

    assign point_count   = (output_points_reg < POINT_CAP) ? output_points_reg : POINT_CAP;
    assign step_past_end = (step_index_reg >= point_count);
    assign step_is_last  = (({1'b0, step_index_reg} + 17'd1) == {1'b0, point_count});

    assign amp_ext   = {7'd0, amp_reg};
    assign fall_diff = amp_ext - fall_total_reg;
    always_comb
    begin
        if (amp_ext <= fall_total_reg)
            value_clamped = '0;
        else if (|fall_diff[47:32])
            value_clamped = '1;
        else
            value_clamped = fall_diff[31:0];
    end

    assign fall_sum = {1'b0, fall_total_reg} + {17'd0, fall_per_step_reg};
    assign fall_sat = fall_sum[48] ? '1 : fall_sum[47:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= IDLE;
            scaled_charge_reg  <= '0;
            peak_value_reg     <= PEAK_RESET;
            peak_index_reg     <= '0;
            samples_loaded_reg <= '0;
            step_index_reg     <= '0;
            decay_power_reg    <= ONE_Q32;
            fall_total_reg     <= '0;
            mul_a_reg          <= '0;
            acc_reg            <= '0;
            amp_reg            <= '0;
            res_value_reg      <= '0;
            res_index_reg      <= '0;
            res_last_reg       <= 1'b0;
            res_beyond_reg     <= 1'b0;
            resp_valid_reg     <= 1'b0;
            resp_value_reg     <= '0;
            resp_index_reg     <= '0;
            resp_last_reg      <= 1'b0;
            resp_beyond_reg    <= 1'b0;
        end
        else
        begin
            // In EMIT the output register is refilled below whenever it drains.
            if (resp_valid_reg && resp.ready && state_reg != EMIT)
                resp_valid_reg <= 1'b0;

            unique case (state_reg)
                IDLE:
                begin
                    if (cmd.valid)
                    begin
                        case (cmd.action)
                            ACT_START:
                            begin
                                peak_value_reg     <= PEAK_RESET;
                                peak_index_reg     <= '0;
                                samples_loaded_reg <= '0;
                                step_index_reg     <= '0;
                                decay_power_reg    <= ONE_Q32;
                                fall_total_reg     <= '0;
                                acc_reg            <= '0;
                                // A negative charge never gives output, so it scales to zero.
                                mul_a_reg <= cmd.charge[CHARGE_W-1] ? '0
                                           : {16'd0, cmd.charge};
                                state_reg <= CHG_LO;
                            end
                            ACT_LOAD:
                            begin
                                if (samples_loaded_reg < SAMPLE_CAP)
                                begin
                                    if (cmd.sample > peak_value_reg)
                                    begin
                                        peak_value_reg <= cmd.sample;
                                        peak_index_reg <= samples_loaded_reg;
                                    end
                                    samples_loaded_reg <= samples_loaded_reg + POINT_W'(1);
                                end
                            end
                            ACT_STEP:
                            begin
                                res_index_reg <= step_index_reg;
                                res_value_reg <= '0;
                                if (step_past_end)
                                begin
                                    res_last_reg   <= 1'b0;
                                    res_beyond_reg <= 1'b1;
                                    state_reg      <= EMIT;
                                end
                                else
                                begin
                                    res_last_reg   <= step_is_last;
                                    res_beyond_reg <= 1'b0;
                                    step_index_reg <= step_index_reg + POINT_W'(1);
                                    if (step_index_reg < peak_index_reg)
                                        state_reg <= EMIT;
                                    else
                                    begin
                                        mul_a_reg <= scaled_charge_reg;
                                        state_reg <= RISE_LO;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                CHG_LO:
                begin
                    acc_reg   <= mul_p[55:16];
                    state_reg <= CHG_HI;
                end
                CHG_HI:
                begin
                    scaled_charge_reg <= mul_sum[39:0];
                    state_reg         <= IDLE;
                end
                RISE_LO:
                begin
                    acc_reg   <= mul_p[55:16];
                    state_reg <= RISE_HI;
                end
                RISE_HI:
                begin
                    amp_reg   <= mul_sum[56:16];
                    mul_a_reg <= {8'd0, decay_power_reg};
                    state_reg <= DEC_LO;
                end
                DEC_LO:
                begin
                    // The value uses the fall total from before this step.
                    res_value_reg <= value_clamped;
                    acc_reg       <= mul_p[55:16];
                    state_reg     <= DEC_HI;
                end
                DEC_HI:
                begin
                    decay_power_reg <= mul_sum[47:16];
                    fall_total_reg  <= fall_sat;
                    state_reg       <= EMIT;
                end
                EMIT:
                begin
                    if (!resp_valid_reg || resp.ready)
                    begin
                        resp_valid_reg  <= 1'b1;
                        resp_value_reg  <= res_value_reg;
                        resp_index_reg  <= res_index_reg;
                        resp_last_reg   <= res_last_reg;
                        resp_beyond_reg <= res_beyond_reg;
                        state_reg       <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign cmd.ready        = (state_reg == IDLE);
    assign resp.valid       = resp_valid_reg;
    assign resp.value       = resp_value_reg;
    assign resp.point_index = resp_index_reg;
    assign resp.last        = resp_last_reg;
    assign resp.beyond_end  = resp_beyond_reg;

endmodule
